[hdl/elf64_header_validator_defines.svh]
// Assertion macros shared by the ELF64 header validator RTL.
`ifndef ELF64_HEADER_VALIDATOR_DEFINES_SVH
`define ELF64_HEADER_VALIDATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define EHV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define EHV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ehv_pkg.sv]
// Types, field offsets and constants of the ELF64 header validator.
package ehv_pkg;

  localparam int unsigned HdrLen  = 64;
  localparam int unsigned HdrIdxW = 6;

  // Header field byte offsets
  localparam int unsigned ClassOff    = 4;
  localparam int unsigned DataOff     = 5;
  localparam int unsigned VersionOff  = 6;
  localparam int unsigned OsabiOff    = 7;
  localparam int unsigned TypeOff     = 16;
  localparam int unsigned MachineOff  = 18;
  localparam int unsigned PhoffOff    = 32;
  localparam int unsigned ShoffOff    = 40;
  localparam int unsigned EhsizeOff   = 52;
  localparam int unsigned PhentOff    = 54;
  localparam int unsigned PhnumOff    = 56;
  localparam int unsigned ShentOff    = 58;
  localparam int unsigned ShndxOff    = 62;

  // Identification and header values
  localparam logic [7:0]  Mag0            = 8'h7f;
  localparam logic [7:0]  Mag1            = 8'h45;
  localparam logic [7:0]  Mag2            = 8'h4c;
  localparam logic [7:0]  Mag3            = 8'h46;
  localparam logic [7:0]  ClassElf64      = 8'd2;
  localparam logic [7:0]  DataLsb         = 8'd1;
  localparam logic [7:0]  OsabiSysv       = 8'd0;
  localparam logic [7:0]  IdentVerCurrent = 8'd1;
  localparam logic [15:0] MachineX8664    = 16'h003e;
  localparam logic [15:0] TypeExec        = 16'h0002;
  localparam logic [15:0] MinEhsize       = 16'd64;
  localparam logic [31:0] SectStrtab      = 32'd3;

  // Offset of the type word inside a section header
  localparam logic [7:0]  ShTypeOff       = 8'd4;

  typedef enum logic [3:0] {
    StOk         = 4'd0,
    StShort      = 4'd1,
    StMagic      = 4'd2,
    StClass      = 4'd3,
    StEncoding   = 4'd4,
    StAbi        = 4'd5,
    StVersion    = 4'd6,
    StMachine    = 4'd7,
    StType       = 4'd8,
    StEhsize     = 4'd9,
    StPhdrBeyond = 4'd10,
    StStrtabBad  = 4'd11
  } status_e;

  typedef logic [HdrLen-1:0][7:0] hdr_t;
  typedef logic [3:0][7:0]        lane_t;

  // Result of the check stage
  typedef struct packed {
    logic    short_img;
    status_e hdr_err;
    logic    phdr_bad;
    logic    strtab_bad;
  } eval_t;

  // Little-endian 16-bit field at a fixed byte offset
  function automatic logic [15:0] hdr_u16(hdr_t h, int unsigned idx);
    return {h[HdrIdxW'(idx + 1)], h[HdrIdxW'(idx)]};
  endfunction

  // Little-endian 64-bit field at a fixed byte offset
  function automatic logic [63:0] hdr_u64(hdr_t h, int unsigned idx);
    logic [63:0] v;
    v = '0;
    for (int k = 0; k < 8; k++) begin
      v[8*k +: 8] = h[HdrIdxW'(idx + k)];
    end
    return v;
  endfunction

endpackage

[hdl/elf64_header_validator.sv]
// Streaming ELF64 executable header validator, one image byte per item.
// Throughput: one byte item per cycle unless a status stall backs up to the input;
//   the shared 16x8 multiplier folds the table sizes in while the header streams, so no byte waits on it.
// Result path: after the final byte the status item passes through the capture stage,
//   check stage and output register; stalls can hold it in any of them.
// Reset: clears the byte counter, the captured-lane mask and all valid flags;
//   header storage needs no clearing and there is no clearing pass.
`include "elf64_header_validator_defines.svh"

module elf64_header_validator #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // last_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [3:0] status, [7:4] zero
);

  localparam int unsigned HW = ehv_pkg::HdrIdxW;

  // Input side state
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  ehv_pkg::hdr_t         hdr_q, hdr_d;
  logic [64:0]           pend_q, pend_d;
  logic [64:0]           off_q, off_d;
  ehv_pkg::lane_t        lval_q, lval_d, lval_upd;
  logic [3:0]            lmsk_q, lmsk_d, lmsk_upd;

  // Capture stage
  logic                  snap_valid_q, snap_valid_d;
  logic [COUNT_BITS-1:0] snap_cnt_q;
  ehv_pkg::hdr_t         snap_hdr_q;
  logic [64:0]           snap_pend_q;
  logic [64:0]           snap_off_q;
  ehv_pkg::lane_t        snap_lval_q;
  logic [3:0]            snap_lmsk_q;

  // Check stage and output register
  logic                  eval_valid_q, eval_valid_d;
  ehv_pkg::eval_t        eval_q, eval_d;
  logic                  out_valid_q, out_valid_d;
  ehv_pkg::status_e      out_status_q, out_status_d;

  logic                  s_acc, snap_load, eval_load, out_load;
  logic                  out_ready, eval_ready, snap_ready;
  logic                  in_hdr, cnt_sat;
  logic [HW-1:0]         pos_lo;
  logic [15:0]           mul_a;
  logic [23:0]           mul_p;
  logic                  ndx_nz, unreach;
  logic [64:0]           lane_dist;
  logic                  lane_hit;

  // Ready chain through the result stages
  assign out_ready  = !out_valid_q || m_axis_tready_i;
  assign eval_ready = !eval_valid_q || out_ready;
  assign snap_ready = !snap_valid_q || eval_ready;

  assign s_axis_tready_o = snap_ready;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign snap_load       = s_acc && s_axis_tlast_i;
  assign eval_load       = snap_valid_q && eval_ready;
  assign out_load        = eval_valid_q && out_ready;

  assign cnt_sat = &cnt_q;
  assign in_hdr  = cnt_q < COUNT_BITS'(ehv_pkg::HdrLen);
  assign pos_lo  = cnt_q[HW-1:0];

  // Shared multiplier: entry size times one byte of the program header count or the string table index
  assign mul_a = (pos_lo == HW'(ehv_pkg::PhnumOff) || pos_lo == HW'(ehv_pkg::PhnumOff + 1))
               ? ehv_pkg::hdr_u16(hdr_q, ehv_pkg::PhentOff)
               : ehv_pkg::hdr_u16(hdr_q, ehv_pkg::ShentOff);
  assign mul_p = 24'(mul_a) * 24'(s_axis_tdata_i);

  // Header capture, running program table end and string table type word offset
  always_comb begin
    hdr_d  = hdr_q;
    pend_d = pend_q;
    off_d  = off_q;
    if (s_acc && in_hdr) begin
      hdr_d[pos_lo] = s_axis_tdata_i;
      if (pos_lo == HW'(ehv_pkg::PhnumOff)) begin
        pend_d = 65'(ehv_pkg::hdr_u64(hdr_q, ehv_pkg::PhoffOff)) + 65'(mul_p);
      end
      if (pos_lo == HW'(ehv_pkg::PhnumOff + 1)) begin
        pend_d = pend_q + 65'({mul_p, 8'd0});
      end
      if (pos_lo == HW'(ehv_pkg::ShndxOff)) begin
        off_d = 65'(ehv_pkg::hdr_u64(hdr_q, ehv_pkg::ShoffOff)) + 65'(mul_p)
              + 65'(ehv_pkg::ShTypeOff);
      end
      if (pos_lo == HW'(ehv_pkg::ShndxOff + 1)) begin
        off_d = off_q + 65'({mul_p, 8'd0});
      end
    end
  end

  // String table type bytes that arrive after the header
  assign ndx_nz    = |{hdr_q[ehv_pkg::ShndxOff + 1], hdr_q[ehv_pkg::ShndxOff]};
  assign unreach   = off_q[64] || (&off_q[63:2]);
  assign lane_dist = 65'(cnt_q) - off_q;
  assign lane_hit  = s_acc && !in_hdr && !cnt_sat && ndx_nz && !unreach
                  && (lane_dist[64:2] == '0);

  always_comb begin
    lval_upd = lval_q;
    lmsk_upd = lmsk_q;
    if (lane_hit) begin
      lval_upd[lane_dist[1:0]] = s_axis_tdata_i;
      lmsk_upd[lane_dist[1:0]] = 1'b1;
    end
    lval_d = lval_upd;
    lmsk_d = snap_load ? 4'd0 : lmsk_upd;
  end

  // Advance the byte counter, holding at saturation; drop back to zero after the final byte
  always_comb begin
    cnt_d = cnt_q;
    if (s_acc) begin
      if (s_axis_tlast_i) begin
        cnt_d = '0;
      end else if (!cnt_sat) begin
        cnt_d = cnt_q + COUNT_BITS'(1);
      end
    end
  end

  // Valid flags of the result stages
  always_comb begin
    snap_valid_d = snap_valid_q;
    if (snap_load) begin
      snap_valid_d = 1'b1;
    end else if (eval_ready) begin
      snap_valid_d = 1'b0;
    end
    eval_valid_d = eval_valid_q;
    if (eval_ready) begin
      eval_valid_d = snap_valid_q;
    end
    out_valid_d = out_valid_q;
    if (out_ready) begin
      out_valid_d = eval_valid_q;
    end
  end

  // Check stage: header checks, table ends, string table type word
  always_comb begin
    logic [63:0]    pend_sat;
    logic [6:0]     lane_pos;
    logic           s_unreach, s_ndx_nz, in_first;
    ehv_pkg::lane_t hval, mval;
    logic [3:0]     hhit, mmsk;

    eval_d.short_img = snap_cnt_q < COUNT_BITS'(ehv_pkg::HdrLen);

    if (snap_hdr_q[0] != ehv_pkg::Mag0 || snap_hdr_q[1] != ehv_pkg::Mag1 ||
        snap_hdr_q[2] != ehv_pkg::Mag2 || snap_hdr_q[3] != ehv_pkg::Mag3) begin
      eval_d.hdr_err = ehv_pkg::StMagic;
    end else if (snap_hdr_q[ehv_pkg::ClassOff] != ehv_pkg::ClassElf64) begin
      eval_d.hdr_err = ehv_pkg::StClass;
    end else if (snap_hdr_q[ehv_pkg::DataOff] != ehv_pkg::DataLsb) begin
      eval_d.hdr_err = ehv_pkg::StEncoding;
    end else if (snap_hdr_q[ehv_pkg::OsabiOff] != ehv_pkg::OsabiSysv) begin
      eval_d.hdr_err = ehv_pkg::StAbi;
    end else if (snap_hdr_q[ehv_pkg::VersionOff] != ehv_pkg::IdentVerCurrent) begin
      eval_d.hdr_err = ehv_pkg::StVersion;
    end else if (ehv_pkg::hdr_u16(snap_hdr_q, ehv_pkg::MachineOff) != ehv_pkg::MachineX8664)
    begin
      eval_d.hdr_err = ehv_pkg::StMachine;
    end else if (ehv_pkg::hdr_u16(snap_hdr_q, ehv_pkg::TypeOff) != ehv_pkg::TypeExec) begin
      eval_d.hdr_err = ehv_pkg::StType;
    end else if (ehv_pkg::hdr_u16(snap_hdr_q, ehv_pkg::EhsizeOff) < ehv_pkg::MinEhsize) begin
      eval_d.hdr_err = ehv_pkg::StEhsize;
    end else begin
      eval_d.hdr_err = ehv_pkg::StOk;
    end

    // A table end past 64 bits saturates to all ones
    pend_sat        = snap_pend_q[64] ? '1 : snap_pend_q[63:0];
    eval_d.phdr_bad = 64'(snap_cnt_q) < pend_sat;

    // Type bytes that lie inside the header come from the captured header
    in_first = (snap_off_q[64:HW] == '0);
    hval     = '0;
    hhit     = '0;
    for (int k = 0; k < 4; k++) begin
      lane_pos = 7'(snap_off_q[HW-1:0]) + 7'(k);
      for (int i = 0; i < ehv_pkg::HdrLen; i++) begin
        if (in_first && lane_pos == 7'(i)) begin
          hval[k] = snap_hdr_q[i];
          hhit[k] = 1'b1;
        end
      end
    end
    for (int k = 0; k < 4; k++) begin
      mval[k] = snap_lmsk_q[k] ? snap_lval_q[k] : hval[k];
    end
    mmsk = snap_lmsk_q | hhit;

    s_unreach = snap_off_q[64] || (&snap_off_q[63:2]);
    s_ndx_nz  = |{snap_hdr_q[ehv_pkg::ShndxOff + 1], snap_hdr_q[ehv_pkg::ShndxOff]};
    eval_d.strtab_bad = s_ndx_nz &&
                        (s_unreach || mmsk != 4'hf || mval != ehv_pkg::SectStrtab);
  end

  // Pick the first failure in check order
  always_comb begin
    if (eval_q.short_img) begin
      out_status_d = ehv_pkg::StShort;
    end else if (eval_q.hdr_err != ehv_pkg::StOk) begin
      out_status_d = eval_q.hdr_err;
    end else if (eval_q.phdr_bad) begin
      out_status_d = ehv_pkg::StPhdrBeyond;
    end else if (eval_q.strtab_bad) begin
      out_status_d = ehv_pkg::StStrtabBad;
    end else begin
      out_status_d = ehv_pkg::StOk;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      lmsk_q       <= '0;
      snap_valid_q <= 1'b0;
      eval_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      cnt_q        <= cnt_d;
      lmsk_q       <= lmsk_d;
      snap_valid_q <= snap_valid_d;
      eval_valid_q <= eval_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    hdr_q  <= hdr_d;
    pend_q <= pend_d;
    off_q  <= off_d;
    lval_q <= lval_d;
    if (snap_load) begin
      snap_cnt_q  <= cnt_sat ? cnt_q : cnt_q + COUNT_BITS'(1);
      snap_hdr_q  <= hdr_d;
      snap_pend_q <= pend_d;
      snap_off_q  <= off_d;
      snap_lval_q <= lval_upd;
      snap_lmsk_q <= lmsk_upd;
    end
    if (eval_load) begin
      eval_q <= eval_d;
    end
    if (out_load) begin
      out_status_q <= out_status_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, out_status_q};

  // Checks
  `EHV_ASSERT_NEXT(a_cnt_clear, clk_i, rst_ni, snap_load, cnt_q == '0, "count not cleared after final byte")
  `EHV_ASSERT_IMPL(a_no_lane_in_hdr, clk_i, rst_ni, cnt_q <= COUNT_BITS'(ehv_pkg::HdrLen), lmsk_q == '0, "type lane captured from stream inside header")
  `EHV_ASSERT_IMPL(a_status_range, clk_i, rst_ni, out_valid_q, out_status_q <= ehv_pkg::StStrtabBad, "status code out of range")

endmodule

[test/elf64_verdict_check.sv]
// Status predictor and result checker for the ELF64 header validator streams.
`timescale 1ns / 1ps

module elf64_verdict_check
  import ehv_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // last_byte
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,   // [3:0] status, [7:4] zero
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned images_done_o,
  output logic [15:0] codes_seen_o
);

  localparam logic [63:0] CountMax      = {64{1'b1}} >> (64 - COUNT_BITS);
  localparam logic [63:0] ShtypeBaseMax = 64'hffff_ffff_ffff_fff7;

  // Per-image tracking state
  logic [7:0]  hdr_bytes [HdrLen];
  logic [63:0] bytes_seen;
  status_e     hdr_verdict;
  logic [63:0] phdr_end;
  logic [63:0] shtype_at;
  logic [31:0] shtype_word;
  logic [2:0]  shtype_got;
  logic        shtype_lost;

  // Status codes owed by images whose final byte was taken
  status_e     owed_status_q [$];

  function automatic logic [15:0] hword16(int unsigned at);
    return {hdr_bytes[at + 1], hdr_bytes[at]};
  endfunction

  function automatic logic [63:0] hword64(int unsigned at);
    logic [63:0] v;
    for (int k = 0; k < 8; k++) begin
      v[8*k +: 8] = hdr_bytes[at + k];
    end
    return v;
  endfunction

  function automatic void clear_image();
    for (int k = 0; k < HdrLen; k++) begin
      hdr_bytes[k] = 8'h00;
    end
    bytes_seen  = '0;
    hdr_verdict = StOk;
    phdr_end    = '0;
    shtype_at   = '0;
    shtype_word = '0;
    shtype_got  = '0;
    shtype_lost = 1'b0;
  endfunction

  // Judge the full header, size the program table, locate the strtab type word
  function automatic void finish_header();
    logic [64:0] sum;
    logic [15:0] ndx;
    if (hdr_bytes[0] != Mag0 || hdr_bytes[1] != Mag1 ||
        hdr_bytes[2] != Mag2 || hdr_bytes[3] != Mag3)         hdr_verdict = StMagic;
    else if (hdr_bytes[ClassOff] != ClassElf64)               hdr_verdict = StClass;
    else if (hdr_bytes[DataOff] != DataLsb)                   hdr_verdict = StEncoding;
    else if (hdr_bytes[OsabiOff] != OsabiSysv)                hdr_verdict = StAbi;
    else if (hdr_bytes[VersionOff] != IdentVerCurrent)        hdr_verdict = StVersion;
    else if (hword16(MachineOff) != MachineX8664)             hdr_verdict = StMachine;
    else if (hword16(TypeOff) != TypeExec)                    hdr_verdict = StType;
    else if (hword16(EhsizeOff) < MinEhsize)                  hdr_verdict = StEhsize;
    else                                                      hdr_verdict = StOk;

    sum = 65'(hword64(PhoffOff)) +
          65'(32'(hword16(PhentOff)) * 32'(hword16(PhnumOff)));
    phdr_end = sum[64] ? {64{1'b1}} : sum[63:0];

    ndx = hword16(ShndxOff);
    if (ndx != 16'd0) begin
      sum = 65'(hword64(ShoffOff)) + 65'(32'(hword16(ShentOff)) * 32'(ndx));
      if (sum[64] || sum[63:0] > ShtypeBaseMax) begin
        shtype_lost = 1'b1;
      end else begin
        shtype_at = sum[63:0] + 64'(ShTypeOff);
        // type bytes that fall inside the header come from the capture
        while (shtype_got < 3'd4 && shtype_at + 64'(shtype_got) < 64'(HdrLen)) begin
          shtype_word[8*shtype_got +: 8] = hdr_bytes[6'(shtype_at + 64'(shtype_got))];
          shtype_got++;
        end
      end
    end
  endfunction

  // Advance the image by one byte; on the final byte report its status
  task automatic absorb_byte(input logic [7:0] b, input logic last,
                             output logic done, output status_e st);
    logic [63:0] pos;
    pos  = bytes_seen;
    done = last;
    st   = StOk;
    if (pos < CountMax) begin
      bytes_seen = pos + 64'd1;
      if (pos < 64'(HdrLen)) begin
        hdr_bytes[pos[5:0]] = b;
        if (pos == 64'(HdrLen - 1)) finish_header();
      end else if (hword16(ShndxOff) != 16'd0 && !shtype_lost && shtype_got < 3'd4 &&
                   pos == shtype_at + 64'(shtype_got)) begin
        shtype_word[8*shtype_got +: 8] = b;
        shtype_got++;
      end
    end
    if (last) begin
      if (bytes_seen < 64'(HdrLen))   st = StShort;
      else if (hdr_verdict != StOk)   st = hdr_verdict;
      else if (bytes_seen < phdr_end) st = StPhdrBeyond;
      else if (hword16(ShndxOff) != 16'd0 &&
               (shtype_lost || shtype_got < 3'd4 || shtype_word != SectStrtab))
        st = StStrtabBad;
      else                            st = StOk;
      clear_image();
    end
  endtask

  // Compare each status item against the oldest owed status, then track input
  always @(posedge clk_i or negedge rst_ni) begin
    logic    done;
    status_e st;
    status_e want;
    if (!rst_ni) begin
      clear_image();
      owed_status_q.delete();
      fail_count_o  = 0;
      pending_o     = 0;
      images_done_o = 0;
      codes_seen_o  = '0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        images_done_o++;
        codes_seen_o[m_axis_tdata_i[3:0]] = 1'b1;
        if (owed_status_q.size() == 0) begin
          $error("status item %0d arrived with no image pending", m_axis_tdata_i[3:0]);
          fail_count_o++;
        end else begin
          want = owed_status_q.pop_front();
          if (m_axis_tdata_i[3:0] !== want) begin
            $error("status mismatch: expected %0d (%s), actual %0d",
                   want, want.name(), m_axis_tdata_i[3:0]);
            fail_count_o++;
          end
          if (m_axis_tdata_i[7:4] !== 4'd0) begin
            $error("pad mismatch: expected 0, actual %0h", m_axis_tdata_i[7:4]);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        absorb_byte(s_axis_tdata_i, s_axis_tlast_i, done, st);
        if (done) owed_status_q.push_back(st);
      end
      pending_o = owed_status_q.size();
    end
  end

endmodule

[test/testbench.sv]
// Top of the ELF64 header validator testbench: image stimulus, stalls and verdict.
`timescale 1ns / 1ps

module testbench;
  import ehv_pkg::*;

  localparam int unsigned CountBits   = 16;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned WatchLimit  = 4000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned RandBytes   = 160;
  localparam int unsigned RandImages  = 2;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned images_done;
  logic [15:0] codes_seen;

  logic [7:0]  img [$];
  int unsigned sent_bytes  = 0;
  int unsigned sent_images = 0;
  int unsigned idle_run    = 0;
  bit          calm        = 1'b0;
  bit          hold_req    = 1'b0;

  elf64_header_validator #(
    .COUNT_BITS(CountBits)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  elf64_verdict_check #(
    .COUNT_BITS(CountBits)
  ) verdict_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .images_done_o   (images_done),
    .codes_seen_o    (codes_seen)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Drain status items, with random stalls and one long hold-off on request
  initial begin
    m_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 6);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run >= WatchLimit) begin
      $display("elf64_header_validator verification failed");
      $finish;
    end
  end

  // Write a little-endian field into the image, dropping bytes past its end
  function automatic void put_le(int unsigned off, logic [63:0] v, int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      if (off + k < img.size()) img[off + k] = v[8*k +: 8];
    end
  endfunction

  // Random bytes under a header that passes every check
  function automatic void base_image(int unsigned len);
    img.delete();
    repeat (len) img.push_back(8'($urandom));
    put_le(0, {Mag3, Mag2, Mag1, Mag0}, 4);
    put_le(ClassOff, ClassElf64, 1);
    put_le(DataOff, DataLsb, 1);
    put_le(VersionOff, IdentVerCurrent, 1);
    put_le(OsabiOff, OsabiSysv, 1);
    put_le(TypeOff, TypeExec, 2);
    put_le(MachineOff, MachineX8664, 2);
    put_le(EhsizeOff, MinEhsize, 2);
    put_le(PhoffOff, 64, 8);
    put_le(PhentOff, 56, 2);
    put_le(PhnumOff, 0, 2);
    put_le(ShoffOff, 0, 8);
    put_le(ShentOff, 64, 2);
    put_le(ShndxOff, 0, 2);
  endfunction

  function automatic void set_phdrs(logic [63:0] phoff, logic [15:0] phent,
                                    logic [15:0] phnum);
    put_le(PhoffOff, phoff, 8);
    put_le(PhentOff, phent, 2);
    put_le(PhnumOff, phnum, 2);
  endfunction

  // Point the string table index at a section header and write its type word
  function automatic void place_strtab(logic [63:0] shoff, logic [15:0] shent,
                                       logic [15:0] ndx, logic [31:0] kind);
    logic [64:0] where;
    put_le(ShoffOff, shoff, 8);
    put_le(ShentOff, shent, 2);
    put_le(ShndxOff, ndx, 2);
    where = 65'(shoff) + 65'(32'(shent) * 32'(ndx)) + 65'(ShTypeOff);
    if (where < 65'(img.size())) put_le(where[31:0], kind, 4);
  endfunction

  // Spoil the header field that the given check looks at
  function automatic void break_header(status_e check);
    int unsigned at;
    logic [7:0]  flip;
    flip = 8'($urandom_range(1, 255));
    case (check)
      StMagic:    at = $urandom_range(0, 3);
      StClass:    at = ClassOff;
      StEncoding: at = DataOff;
      StAbi:      at = OsabiOff;
      StVersion:  at = VersionOff;
      StMachine:  at = MachineOff + $urandom_range(0, 1);
      StType:     at = TypeOff + $urandom_range(0, 1);
      default:    at = img.size();
    endcase
    if (check == StEhsize) put_le(EhsizeOff, $urandom_range(0, MinEhsize - 1), 2);
    else if (at < img.size()) img[at] ^= flip;
  endfunction

  // Offer one byte, idling at random first, and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(99) < 6) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
    sent_bytes++;
  endtask

  task automatic run_image();
    for (int unsigned i = 0; i < img.size(); i++) begin
      send_byte(img[i], i == img.size() - 1);
    end
    sent_images++;
  endtask

  // Mostly well-formed images with random layout, some spoiled, some noise
  task automatic random_image();
    int unsigned pick;
    int unsigned len;
    int unsigned pent;
    int unsigned pnum;
    int unsigned base;
    int unsigned shent;
    int unsigned ndx;
    int unsigned spoil;
    pick = $urandom_range(99);
    if (pick < 8) begin
      len = $urandom_range(1, 90);
      img.delete();
      repeat (len) img.push_back(8'($urandom));
    end else begin
      len = (pick < 14) ? $urandom_range(1, 63) : $urandom_range(64, 96);
      base_image(len);
      pent = $urandom_range(0, 64);
      pnum = $urandom_range(0, 3);
      if (len < 64 + pent * pnum) pnum = 0;
      set_phdrs($urandom_range(64, len - pent * pnum), pent, pnum);
      if ($urandom_range(1) == 1) begin
        ndx   = $urandom_range(1, 4);
        shent = $urandom_range(0, 16);
        base  = ($urandom_range(3) == 0) ? $urandom_range(0, 56)
                                         : $urandom_range(60, len + 4);
        if (shent * ndx > base) shent = 0;
        place_strtab(base - shent * ndx, shent, ndx, SectStrtab);
      end
      if ($urandom_range(99) < 40) begin
        spoil = $urandom_range(0, 11);
        if (spoil <= StEhsize - StMagic) begin
          break_header(status_e'(StMagic + spoil));
        end else begin
          case (spoil)
            8:  set_phdrs({$urandom, $urandom}, 16'($urandom), 16'($urandom));
            9:  place_strtab(64, 0, 1, $urandom);
            10: place_strtab({$urandom, $urandom}, 16'($urandom), 16'($urandom),
                             SectStrtab);
            default: put_le(ShndxOff, 0, 2);
          endcase
        end
      end
    end
    run_image();
  endtask

  initial begin
    int unsigned bytes_at;
    int unsigned images_at;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    s_tlast  = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // short images: one byte, and one byte less than a header
    base_image(1);   run_image();
    base_image(63);  run_image();
    // each header check on its own without any idling, then two at once
    calm = 1'b1;
    for (int k = 0; k <= StEhsize - StMagic; k++) begin
      base_image(64);
      break_header(status_e'(StMagic + k));
      run_image();
    end
    calm = 1'b0;
    base_image(64);  break_header(StAbi);   break_header(StVersion); run_image();
    // program table ending exactly at the image end, one past it, overflowing
    base_image(72);  set_phdrs(16, 28, 2); run_image();
    base_image(72);  set_phdrs(17, 28, 2); run_image();
    base_image(64);  set_phdrs({64{1'b1}}, 1, 1); run_image();
    // string table: wrong type, beyond the image, cut short by the image end
    base_image(72);  place_strtab(64, 0, 1, SectStrtab ^ 32'd1); run_image();
    base_image(72);  place_strtab(64, 8, 1, SectStrtab); run_image();
    base_image(70);  place_strtab(58, 6, 1, SectStrtab); run_image();
    // string table offset overflowing, or too close to the top of the range
    base_image(64);  place_strtab({64{1'b1}}, 1, 1, SectStrtab); run_image();
    base_image(64);  place_strtab(64'hffff_ffff_ffff_fff8, 0, 1, SectStrtab); run_image();
    // type word inside the header, and straddling the header end
    base_image(64);  place_strtab(0, 20, 1, SectStrtab); run_image();
    base_image(70);  place_strtab(58, 0, 3, SectStrtab); run_image();

    // stall the status side while short images keep coming
    hold_req = 1'b1;
    repeat (10) begin
      base_image($urandom_range(1, 3));
      run_image();
    end

    // random images with random idling
    bytes_at  = sent_bytes;
    images_at = sent_images;
    while (sent_bytes - bytes_at < RandBytes || sent_images - images_at < RandImages) begin
      random_image();
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Sent %0d images in %0d bytes, %0d status items checked, with a stretch",
             sent_images, sent_bytes, images_done);
    $display("free of idling and a %0d-cycle output hold-off; codes seen (bit n = code n): %b",
             HoldCycles, codes_seen[11:0]);
    if (fail_count == 0) begin
      $display("elf64_header_validator verification clean");
    end else begin
      $display("elf64_header_validator verification failed");
    end
    $finish;
  end

endmodule
